### sv/jbsc_pkg.sv
// Shared types, code unit constants and helpers for the bracket structure checker.
`default_nettype none

package jbsc_pkg;

	localparam logic [15:0] CU_LSQ   = 16'h005B;
	localparam logic [15:0] CU_RSQ   = 16'h005D;
	localparam logic [15:0] CU_LCUR  = 16'h007B;
	localparam logic [15:0] CU_RCUR  = 16'h007D;
	localparam logic [15:0] CU_QUOTE = 16'h0022;
	localparam logic [15:0] CU_BSL   = 16'h005C;

	// bracket kinds as held on the stack
	localparam logic KIND_SQUARE = 1'b0;
	localparam logic KIND_CURLY  = 1'b1;

	typedef enum logic [1:0] {
		PH_BEFORE = 2'd0,
		PH_INSIDE = 2'd1,
		PH_AFTER  = 2'd2
	} phase_t;

	typedef struct packed {
		logic depth_overflow;
		logic complete;
	} res_t;

	function automatic logic is_ws(input logic [15:0] c);
		return c inside {16'h0020, [16'h0009:16'h000D]};
	endfunction

endpackage

`default_nettype wire

### sv/jbsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module jbsc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/jbsc_out_skid.sv
// Output register with a skid stage so the input side keeps moving while a result waits.
`default_nettype none

module jbsc_out_skid
	import jbsc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire res_t in_res,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_res
);

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;
	logic take;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;
	assign take      = !main_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			main_q <= skid_valid_q ? skid_q : in_res;
		end else if (in_valid) begin
			skid_q <= in_res;
		end
	end

endmodule

`default_nettype wire

### sv/json_bracket_structure_checker_unit.sv
// Top level: streaming bracket structure checker over UTF-16 text.
//
// Input: one code unit per transfer on s_tdata[15:0], s_tlast marks the final unit
// of a text. Output: one transfer per text, taken after its last unit, with
// m_tdata[0] = complete and m_tdata[1] = depth_overflow.
// Throughput is one code unit per cycle while s_tready is high. The bracket kinds live in a
// RAM of MAX_DEPTH one-bit entries; the top of stack is held in a register and
// the RAM is read every cycle at the entry below it, so a pop always finds the
// new top ready in the cycle after the last change.
// The result is registered in the output buffer and shows on m_tvalid once earlier results are taken.
// A two-entry output buffer decouples the sides: s_tready only falls when two
// results are waiting on a stalled receiver, and rises again once one is taken.
// After a last unit all parsing state is back at its reset value, ready for the
// next text with no gap. Reset (arst_n low) clears the parser and output buffer;
// the RAM needs no clearing since only values from pushed entries are ever used.
`default_nettype none

module json_bracket_structure_checker_unit
	import jbsc_pkg::*;
#(
	parameter int MAX_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [15:0] code_unit
	input  wire logic        s_tlast,  // is_last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata   // [0] complete, [1] depth_overflow, [7:2] zero
);

	localparam int NW = $clog2(MAX_DEPTH + 1);
	localparam int AW = $clog2(MAX_DEPTH);

	phase_t        phase_q, phase_d;
	logic [NW-1:0] nest_q, nest_d;
	logic          quote_q, quote_d;
	logic          bsl_q, bsl_d;
	logic          failed_q, failed_d;
	logic          ovf_q, ovf_d;
	logic          tos_q, tos_d;

	logic          accept;
	logic [15:0]   cu;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic          below_top;
	logic [NW-1:0] rd_ptr;
	logic          do_push, do_pop;
	logic          kind;
	res_t          res;
	res_t          out_res;

	assign accept = s_tvalid && s_tready;
	assign cu     = s_tdata;

	always_comb begin
		phase_d   = phase_q;
		nest_d    = nest_q;
		quote_d   = quote_q;
		bsl_d     = bsl_q;
		failed_d  = failed_q;
		ovf_d     = ovf_q;
		tos_d     = tos_q;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		kind      = KIND_SQUARE;
		ram_we    = 1'b0;
		ram_waddr = nest_q[AW-1:0];
		ram_wdata = KIND_SQUARE;
		res       = '0;

		if (accept && !failed_q) begin
			case (phase_q)
				PH_BEFORE: begin
					if (!is_ws(cu)) begin
						if (cu == CU_LSQ) begin
							phase_d = PH_INSIDE;
							do_push = 1'b1;
						end else begin
							failed_d = 1'b1;
						end
					end
				end
				PH_INSIDE: begin
					if (quote_q) begin
						if (bsl_q) begin
							bsl_d = 1'b0;
						end else if (cu == CU_BSL) begin
							bsl_d = 1'b1;
						end else if (cu == CU_QUOTE) begin
							quote_d = 1'b0;
						end
					end else begin
						case (cu)
							CU_QUOTE: quote_d = 1'b1;
							CU_LSQ: do_push = 1'b1;
							CU_LCUR: begin
								do_push = 1'b1;
								kind    = KIND_CURLY;
							end
							CU_RSQ: do_pop = 1'b1;
							CU_RCUR: begin
								do_pop = 1'b1;
								kind   = KIND_CURLY;
							end
							default: ;
						endcase
					end
				end
				default: begin
					if (!is_ws(cu)) begin
						failed_d = 1'b1;
					end
				end
			endcase
		end

		if (do_push) begin
			if (nest_q == NW'(MAX_DEPTH)) begin
				failed_d = 1'b1;
				ovf_d    = 1'b1;
			end else begin
				ram_we    = 1'b1;
				ram_wdata = kind;
				tos_d     = kind;
				nest_d    = nest_q + NW'(1);
			end
		end

		if (do_pop) begin
			if (nest_q == '0 || tos_q != kind) begin
				failed_d = 1'b1;
			end else begin
				nest_d = nest_q - NW'(1);
				tos_d  = below_top;
				if (kind == KIND_SQUARE && nest_q == NW'(1)) begin
					phase_d = PH_AFTER;
				end
			end
		end

		if (accept && s_tlast) begin
			res.complete = !failed_d && phase_d == PH_AFTER && !quote_d && !bsl_d
				&& nest_d == '0;
			res.depth_overflow = ovf_d;
			phase_d  = PH_BEFORE;
			nest_d   = '0;
			quote_d  = 1'b0;
			bsl_d    = 1'b0;
			failed_d = 1'b0;
			ovf_d    = 1'b0;
		end
	end

	// keep the entry under the next top of stack on the read port
	assign rd_ptr    = nest_d - NW'(2);
	assign ram_raddr = rd_ptr[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BEFORE;
			nest_q   <= '0;
			quote_q  <= 1'b0;
			bsl_q    <= 1'b0;
			failed_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			nest_q   <= nest_d;
			quote_q  <= quote_d;
			bsl_q    <= bsl_d;
			failed_q <= failed_d;
			ovf_q    <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		tos_q <= tos_d;
	end

	jbsc_ram #(
		.WIDTH(1),
		.DEPTH(MAX_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(below_top)
	);

	jbsc_out_skid u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept && s_tlast),
		.in_ready (s_tready),
		.in_res   (res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = {6'b0, out_res};

`ifndef ASSERT_OFF
	a_nest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nest_q <= NW'(MAX_DEPTH))
		else $error("nesting level beyond stack depth");

	a_before_empty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BEFORE |-> nest_q == '0 && !quote_q && !bsl_q)
		else $error("stack or string state set before the root");

	a_after_empty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_AFTER |-> nest_q == '0)
		else $error("brackets open after the root closed");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=>
			phase_q == PH_BEFORE && nest_q == '0 && !failed_q && !ovf_q)
		else $error("state not cleared after the last unit");
`endif

endmodule

`default_nettype wire
